### design/pfe_pkg.sv
// Package for the Playfair digraph encryptor: square geometry, letter codes,
// pair queue sizing, configuration register indexes and shared types.
// No dependencies.
package pfe_pkg;

    localparam int SIDE        = 5;
    localparam int CELLS       = SIDE * SIDE;
    localparam int LETTER_W    = 5;
    localparam int COORD_W     = 3;
    localparam int PART_CELLS  = 12;
    localparam int CFG_DATA_W  = PART_CELLS * LETTER_W;
    localparam int CFG_INDEX_W = 2;

    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

    typedef logic [LETTER_W-1:0] letter_t;
    typedef logic [COORD_W-1:0]  coord_t;

    localparam letter_t PAD_LETTER = letter_t'(23);
    localparam letter_t CODE_I     = letter_t'(8);
    localparam letter_t CODE_J     = letter_t'(9);

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_SQUARE_A     = 2'd0,
        CFG_SQUARE_B     = 2'd1,
        CFG_SQUARE_FINAL = 2'd2
    } cfg_index_t;

    // key square, cell k = row*SIDE + col
    typedef logic [CELLS-1:0][LETTER_W-1:0] square_t;

    typedef struct packed {
        coord_t row;
        coord_t col;
    } pos_t;

    // plaintext pair waiting for encryption
    typedef struct packed {
        letter_t first;
        letter_t second;
        logic    last;
    } pair_t;

endpackage

### design/playfair_digraph_encrypt_unit.sv
// Playfair digraph encryptor top level: pairing front end, pair queue,
// square lookup stage and cipher output register.
// Depends on pfe_pkg.
// A closed pair passes the queue, then the lookup and cipher output registers.
// Throughput: one letter per cycle in while in_ready is high, one pair per
// cycle out while out_ready is high; the two-stage lookup/cipher pipeline is
// the only pair path; the 4-entry queue takes both pairs of a final repeat.
// Reset (rst_n low, async): key square all zero (every cell is 'a'), no letter
// pending, queue and pipeline empty.
module playfair_digraph_encrypt_unit
    import pfe_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,

    // plaintext channel
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [LETTER_W-1:0]    letter,
    input  logic                   end_of_message,

    // ciphertext channel, one beat per pair
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [LETTER_W-1:0]    cipher_first,
    output logic [LETTER_W-1:0]    cipher_second,
    output logic                   last_pair,

    // configuration write channel
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    // ------------------------------------------------------------------
    // Key square registers
    // ------------------------------------------------------------------
    logic [CFG_DATA_W-1:0] square_a_reg, square_a_next;
    logic [CFG_DATA_W-1:0] square_b_reg, square_b_next;
    letter_t               square_final_reg, square_final_next;
    square_t               square;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        square_a_next     = square_a_reg;
        square_b_next     = square_b_reg;
        square_final_next = square_final_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_SQUARE_A:     square_a_next     = cfg_data;
                CFG_SQUARE_B:     square_b_next     = cfg_data;
                CFG_SQUARE_FINAL: square_final_next = cfg_data[LETTER_W-1:0];
                default:          ; // unknown index: write dropped
            endcase
        end
    end

    // flatten the three registers into row-major cells
    always_comb
    begin
        for (int k = 0; k < PART_CELLS; k++)
        begin
            square[k]              = square_a_reg[k*LETTER_W +: LETTER_W];
            square[k + PART_CELLS] = square_b_reg[k*LETTER_W +: LETTER_W];
        end
        square[CELLS-1] = square_final_reg;
    end

    // ------------------------------------------------------------------
    // Helpers
    // ------------------------------------------------------------------
    // First row-major cell holding code; failing that, its i/j partner;
    // failing that, the top-left corner.
    function automatic pos_t locate(letter_t code, square_t sq);
        logic [CELLS-1:0] hit;
        logic [CELLS-1:0] alt;
        logic [CELLS-1:0] sel;
        letter_t          partner;
        logic             has_partner;
        pos_t             pos;
        partner     = (code == CODE_I) ? CODE_J : CODE_I;
        has_partner = (code == CODE_I) || (code == CODE_J);
        for (int k = 0; k < CELLS; k++)
        begin
            hit[k] = (sq[k] == code);
            alt[k] = has_partner && (sq[k] == partner);
        end
        sel = (|hit) ? hit : alt;
        pos = '0;
        for (int k = CELLS - 1; k >= 0; k--)
        begin
            if (sel[k])
            begin
                pos.row = coord_t'(k / SIDE);
                pos.col = coord_t'(k % SIDE);
            end
        end
        return pos;
    endfunction

    function automatic coord_t wrap_inc(coord_t v);
        return (v == coord_t'(SIDE - 1)) ? '0 : v + coord_t'(1);
    endfunction

    function automatic logic [LETTER_W-1:0] cell_index(coord_t row, coord_t col);
        return LETTER_W'(row * SIDE + col);
    endfunction

    // ------------------------------------------------------------------
    // Pairing front end
    // ------------------------------------------------------------------
    logic    pend_valid_reg, pend_valid_next;
    letter_t pend_letter_reg, pend_letter_next;
    logic    in_fire;
    logic    push0, push1;
    pair_t   pair0, pair1;

    assign in_fire = in_valid && in_ready;

    always_comb
    begin
        pend_valid_next  = pend_valid_reg;
        pend_letter_next = pend_letter_reg;
        push0            = 1'b0;
        push1            = 1'b0;
        pair0            = '{first: pend_letter_reg, second: letter, last: end_of_message};
        pair1            = '{first: letter, second: PAD_LETTER, last: 1'b1};
        if (in_fire)
        begin
            priority if (!pend_valid_reg)
            begin
                // lone letter: pad it at end of message, else hold it
                if (end_of_message)
                begin
                    push0 = 1'b1;
                    pair0 = '{first: letter, second: PAD_LETTER, last: 1'b1};
                end
                else
                begin
                    pend_valid_next  = 1'b1;
                    pend_letter_next = letter;
                end
            end
            else if (pend_letter_reg != letter)
            begin
                push0           = 1'b1;
                pend_valid_next = 1'b0;
            end
            else
            begin
                // repeat: pad the held letter, the new one takes its place
                push0 = 1'b1;
                pair0 = '{first: pend_letter_reg, second: PAD_LETTER, last: 1'b0};
                if (end_of_message)
                begin
                    push1           = 1'b1;
                    pend_valid_next = 1'b0;
                end
                else
                begin
                    pend_letter_next = letter;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Pair queue, room for two pushes guarantees no overflow
    // ------------------------------------------------------------------
    pair_t                 fifo_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0] count_reg, count_next;
    logic                  pop;
    pair_t                 head;

    assign in_ready = (count_reg <= FIFO_CNT_W'(FIFO_DEPTH - 2));
    assign head     = fifo_reg[rd_ptr_reg];

    // ------------------------------------------------------------------
    // Lookup stage and output register
    // ------------------------------------------------------------------
    logic loc_valid_reg, loc_valid_next;
    pos_t loc_first_reg, loc_second_reg;
    logic loc_last_reg;
    logic loc_free;
    logic out_free;

    logic    out_valid_reg, out_valid_next;
    letter_t cipher_first_reg, cipher_second_reg;
    logic    last_pair_reg;

    assign out_free = !out_valid_reg || out_ready;
    assign loc_free = !loc_valid_reg || out_free;
    assign pop      = (count_reg != '0) && loc_free;

    assign wr_ptr_next    = wr_ptr_reg + FIFO_PTR_W'(push0) + FIFO_PTR_W'(push1);
    assign rd_ptr_next    = rd_ptr_reg + FIFO_PTR_W'(pop);
    assign count_next     = count_reg + FIFO_CNT_W'(push0) + FIFO_CNT_W'(push1)
                          - FIFO_CNT_W'(pop);
    assign loc_valid_next = loc_free ? pop : loc_valid_reg;
    assign out_valid_next = out_free ? loc_valid_reg : out_valid_reg;

    // cipher rules on registered coordinates
    logic                same_row, same_col;
    logic [LETTER_W-1:0] idx_first, idx_second;

    always_comb
    begin
        same_row = (loc_first_reg.row == loc_second_reg.row);
        same_col = (loc_first_reg.col == loc_second_reg.col);
        priority if (same_row)
        begin
            // also covers a pair of equal letters
            idx_first  = cell_index(loc_first_reg.row, wrap_inc(loc_first_reg.col));
            idx_second = cell_index(loc_second_reg.row, wrap_inc(loc_second_reg.col));
        end
        else if (same_col)
        begin
            idx_first  = cell_index(wrap_inc(loc_first_reg.row), loc_first_reg.col);
            idx_second = cell_index(wrap_inc(loc_second_reg.row), loc_second_reg.col);
        end
        else
        begin
            // rectangle corners: own row, partner's column
            idx_first  = cell_index(loc_first_reg.row, loc_second_reg.col);
            idx_second = cell_index(loc_second_reg.row, loc_first_reg.col);
        end
    end

    assign out_valid     = out_valid_reg;
    assign cipher_first  = cipher_first_reg;
    assign cipher_second = cipher_second_reg;
    assign last_pair     = last_pair_reg;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            square_a_reg     <= '0;
            square_b_reg     <= '0;
            square_final_reg <= '0;
            pend_valid_reg   <= 1'b0;
            pend_letter_reg  <= '0;
            wr_ptr_reg       <= '0;
            rd_ptr_reg       <= '0;
            count_reg        <= '0;
            loc_valid_reg    <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            square_a_reg     <= square_a_next;
            square_b_reg     <= square_b_next;
            square_final_reg <= square_final_next;
            pend_valid_reg   <= pend_valid_next;
            pend_letter_reg  <= pend_letter_next;
            wr_ptr_reg       <= wr_ptr_next;
            rd_ptr_reg       <= rd_ptr_next;
            count_reg        <= count_next;
            loc_valid_reg    <= loc_valid_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (push0)
        begin
            fifo_reg[wr_ptr_reg] <= pair0;
        end
        if (push1)
        begin
            fifo_reg[wr_ptr_reg + FIFO_PTR_W'(1)] <= pair1;
        end
        if (pop)
        begin
            loc_first_reg  <= locate(head.first, square);
            loc_second_reg <= locate(head.second, square);
            loc_last_reg   <= head.last;
        end
        if (out_free && loc_valid_reg)
        begin
            cipher_first_reg  <= square[idx_first];
            cipher_second_reg <= square[idx_second];
            last_pair_reg     <= loc_last_reg;
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FIFO_CNT_W'(FIFO_DEPTH))
        else $error("pair queue overfilled");

    a_eom_clears_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && end_of_message) |=> !pend_valid_reg)
        else $error("letter still pending after end of message");

    a_double_push: assert property (@(posedge clk) disable iff (!rst_n)
        push1 |-> (pend_valid_reg && end_of_message && (pend_letter_reg == letter)))
        else $error("second pair pushed outside repeat at end of message");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |=> (loc_valid_reg == 1'b0 || $stable(loc_first_reg)))
        else $error("lookup stage loaded from empty queue");

endmodule

### dv/tb_playfair_digraph_encrypt_unit.sv
// Self-checking testbench for playfair_digraph_encrypt_unit: letter stream in,
// enciphered pairs out, key square loaded through the config write channel.
// Depends on pfe_pkg and the design; predicts every pair on its own.
module tb_playfair_digraph_encrypt_unit
    import pfe_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // Index that decodes to no register; the write must be dropped.
    localparam logic [CFG_INDEX_W-1:0] CFG_UNMAPPED = 2'd3;

    localparam int GAP_PCT      = 38;   // chance of an idle cycle on either side
    localparam int HOLD_CYCLES  = 200;  // long receiver back-pressure stretch
    localparam int SETTLE_CYCLES = 8;   // margin after the last pair is seen
    localparam int STALL_LIMIT  = 4000; // cycles with no beat on any channel
    localparam int PHASE_ITEMS  = 250;
    localparam int PRINT_CAP    = 50;

    typedef struct packed {
        letter_t code;
        logic    eom;
    } plain_beat_t;

    typedef struct packed {
        letter_t lead;
        letter_t trail;
        logic    closing;
    } cipher_beat_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_ready;
    logic [LETTER_W-1:0]    letter = '0;
    logic                   end_of_message = 1'b0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic [LETTER_W-1:0]    cipher_first;
    logic [LETTER_W-1:0]    cipher_second;
    logic                   last_pair;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    playfair_digraph_encrypt_unit dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .letter         (letter),
        .end_of_message (end_of_message),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .cipher_first   (cipher_first),
        .cipher_second  (cipher_second),
        .last_pair      (last_pair),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always #1 clk = ~clk;

    // Testbench copy of the key square registers and of the pairing state.
    logic [CFG_DATA_W-1:0] sq_a = '0;
    logic [CFG_DATA_W-1:0] sq_b = '0;
    letter_t               sq_last = '0;
    letter_t               held_code = '0;
    logic                  held_live = 1'b0;

    plain_beat_t  letters_q [$];   // letters waiting to be driven
    cipher_beat_t pairs_due [$];   // enciphered pairs not yet seen at the output
    plain_beat_t  on_wire;         // letter currently offered on the input
    int           miss_count = 0;
    int           beat_count = 0;
    logic         gapless = 1'b0;  // no idle cycles on either side
    logic         want_hold = 1'b0;
    logic         hold_taken = 1'b0;
    int           hold_left = 0;
    int           quiet_cycles = 0;

    task automatic log_miss(input string msg);
        miss_count++;
        if (miss_count <= PRINT_CAP)
            $display("%0t ERROR %s", $realtime, msg);
    endtask

    // ---------------------------------------------------------------
    // Pair prediction
    // ---------------------------------------------------------------
    function automatic letter_t cell_code(input int k);
        if (k < PART_CELLS)
            return sq_a[LETTER_W*k +: LETTER_W];
        if (k < 2*PART_CELLS)
            return sq_b[LETTER_W*(k-PART_CELLS) +: LETTER_W];
        return sq_last;
    endfunction

    // first match in row-major order, -1 when absent
    function automatic int first_cell(input letter_t code);
        for (int k = 0; k < CELLS; k++)
            if (cell_code(k) == code)
                return k;
        return -1;
    endfunction

    // i and j stand in for each other; anything still missing sits at cell 0
    function automatic int cell_of(input letter_t code);
        int k;
        k = first_cell(code);
        if (k < 0 && code == CODE_I)
            k = first_cell(CODE_J);
        else if (k < 0 && code == CODE_J)
            k = first_cell(CODE_I);
        return (k < 0) ? 0 : k;
    endfunction

    function automatic void encipher_pair(input letter_t p, input letter_t q,
                                          input logic closing);
        int pa, pb, r1, c1, r2, c2;
        cipher_beat_t beat;
        pa = cell_of(p);
        pb = cell_of(q);
        r1 = pa / SIDE;
        c1 = pa % SIDE;
        r2 = pb / SIDE;
        c2 = pb % SIDE;
        if (r1 == r2)
        begin
            // same row, also taken by a pair of equal letters
            beat.lead  = cell_code(r1*SIDE + (c1+1) % SIDE);
            beat.trail = cell_code(r2*SIDE + (c2+1) % SIDE);
        end
        else if (c1 == c2)
        begin
            beat.lead  = cell_code(((r1+1) % SIDE)*SIDE + c1);
            beat.trail = cell_code(((r2+1) % SIDE)*SIDE + c2);
        end
        else
        begin
            // rectangle corners: own row, partner's column
            beat.lead  = cell_code(r1*SIDE + c2);
            beat.trail = cell_code(r2*SIDE + c1);
        end
        beat.closing = closing;
        pairs_due.insert(pairs_due.size(), beat);
    endfunction

    // Digraph forming: one letter held; a repeat is split with the pad letter.
    function automatic void pair_up(input plain_beat_t b);
        if (!held_live)
        begin
            if (b.eom)
                encipher_pair(b.code, PAD_LETTER, 1'b1);
            else
            begin
                held_code = b.code;
                held_live = 1'b1;
            end
        end
        else if (held_code != b.code)
        begin
            encipher_pair(held_code, b.code, b.eom);
            held_live = 1'b0;
        end
        else
        begin
            encipher_pair(held_code, PAD_LETTER, 1'b0);
            if (b.eom)
            begin
                // repeat on the last letter: two pairs, second one closes
                encipher_pair(b.code, PAD_LETTER, 1'b1);
                held_live = 1'b0;
            end
        end
    endfunction

    // ---------------------------------------------------------------
    // Input driver: offers queued letters, idles at random between beats.
    // Valid holds with a stable payload until the beat is taken.
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && in_ready)
                pair_up(on_wire);
            if (!in_valid || in_ready)
            begin
                if (letters_q.size() != 0 &&
                    (gapless || $urandom_range(99) >= GAP_PCT))
                begin
                    on_wire = letters_q.pop_front();
                    in_valid       <= 1'b1;
                    letter         <= on_wire.code;
                    end_of_message <= on_wire.eom;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // Output monitor: checks each pair beat against the oldest prediction.
    // Once per run it withholds ready for a long stretch so the pair queue
    // fills and in_ready has to drop.
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        cipher_beat_t want;
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                beat_count++;
                if (pairs_due.size() == 0)
                    log_miss($sformatf("pair beat %0d (%0d %0d last %0b) with none due",
                                       beat_count, cipher_first, cipher_second,
                                       last_pair));
                else
                begin
                    want = pairs_due.pop_front();
                    if (cipher_first !== want.lead || cipher_second !== want.trail ||
                        last_pair !== want.closing)
                        log_miss($sformatf({"pair beat %0d: got %0d %0d last %0b,",
                                            " want %0d %0d last %0b"},
                                           beat_count, cipher_first, cipher_second,
                                           last_pair, want.lead, want.trail,
                                           want.closing));
                end
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (want_hold && !hold_taken)
            begin
                hold_taken = 1'b1;
                hold_left  = HOLD_CYCLES;
                out_ready <= 1'b0;
            end
            else
                out_ready <= gapless || ($urandom_range(99) >= GAP_PCT);
        end
    end

    // Watchdog: too long without a beat on any channel ends the run.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) ||
                (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("%0t ERROR no beat for %0d cycles, %0d pairs due",
                         $realtime, quiet_cycles, pairs_due.size());
                $display("playfair_digraph_encrypt_unit: mismatch");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------

    // Writes the three square registers back to back, valid held across beats.
    // Optionally slips in a write to the unmapped index, which must be ignored.
    task automatic program_square(input logic [CFG_DATA_W-1:0] a,
                                  input logic [CFG_DATA_W-1:0] b,
                                  input letter_t f, input bit junk);
        logic [CFG_INDEX_W-1:0] idx [$];
        logic [CFG_DATA_W-1:0]  val [$];
        logic [63:0]            noise;
        noise = {$urandom, $urandom};
        idx = '{CFG_SQUARE_A, CFG_SQUARE_B, CFG_SQUARE_FINAL};
        val = '{a, b, CFG_DATA_W'(f)};
        if (junk)
        begin
            idx.insert(1, CFG_UNMAPPED);
            val.insert(1, noise[CFG_DATA_W-1:0]);
        end
        @(posedge clk);
        foreach (idx[n])
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[n];
            cfg_data  <= val[n];
            do @(posedge clk); while (!cfg_ready);
            case (idx[n])
                CFG_SQUARE_A:     sq_a = val[n];
                CFG_SQUARE_B:     sq_b = val[n];
                CFG_SQUARE_FINAL: sq_last = val[n][LETTER_W-1:0];
                default: ;
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic load_cells(input letter_t cells [CELLS], input bit junk);
        logic [CFG_DATA_W-1:0] a, b;
        for (int k = 0; k < PART_CELLS; k++)
        begin
            a[LETTER_W*k +: LETTER_W] = cells[k];
            b[LETTER_W*k +: LETTER_W] = cells[PART_CELLS + k];
        end
        program_square(a, b, cells[CELLS-1], junk);
    endtask

    // proper key square: 25 distinct letters, i or j left out, shuffled
    task automatic load_shuffled_square(input bit junk);
        letter_t pool [CELLS];
        letter_t skip, t;
        int k, j;
        skip = $urandom_range(1) ? CODE_J : CODE_I;
        k = 0;
        for (int c = 0; c < 26; c++)
            if (letter_t'(c) != skip)
            begin
                pool[k] = letter_t'(c);
                k++;
            end
        for (int n = CELLS-1; n > 0; n--)
        begin
            j = $urandom_range(n);
            t = pool[n];
            pool[n] = pool[j];
            pool[j] = t;
        end
        load_cells(pool, junk);
    endtask

    task automatic load_text_square(input string s);
        letter_t cells [CELLS];
        for (int k = 0; k < CELLS; k++)
            cells[k] = letter_t'(s[k] - "a");
        load_cells(cells, 1'b0);
    endtask

    task automatic push_text(input string s, input bit eom_at_end);
        plain_beat_t b;
        for (int n = 0; n < s.len(); n++)
        begin
            b.code = letter_t'(s[n] - "a");
            b.eom  = eom_at_end && (n == s.len() - 1);
            letters_q.insert(letters_q.size(), b);
        end
    endtask

    // Mostly well-formed messages with frequent repeats; some stray beats
    // with a random end-of-message flag.
    task automatic push_random_letters(input int count);
        plain_beat_t b;
        int len, pushed;
        pushed = 0;
        while (pushed < count)
        begin
            if ($urandom_range(9) == 0)
            begin
                b.code = letter_t'($urandom_range(25));
                b.eom  = 1'($urandom_range(1));
                letters_q.insert(letters_q.size(), b);
                pushed++;
            end
            else
            begin
                len = $urandom_range(1, 10);
                b.code = letter_t'($urandom_range(25));
                for (int n = 0; n < len; n++)
                begin
                    if (n > 0 && $urandom_range(3) != 0)
                        b.code = letter_t'($urandom_range(25));
                    b.eom = (n == len - 1);
                    letters_q.insert(letters_q.size(), b);
                end
                pushed += len;
            end
        end
        // close any message left open so nothing is stranded
        b.code = letter_t'($urandom_range(25));
        b.eom  = 1'b1;
        letters_q.insert(letters_q.size(), b);
    endtask

    // Block is idle once everything is driven and every pair has come back;
    // the extra cycles cover a letter still moving through the front end.
    task automatic settle();
        @(posedge clk);
        while (letters_q.size() != 0 || in_valid || pairs_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // ---------------------------------------------------------------
    // Test sequence
    // ---------------------------------------------------------------
    initial
    begin
        logic [CFG_DATA_W-1:0] ra, rb;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Reset square is all 'a': every lookup lands on cell 0, duplicates
        // everywhere, i and j both missing.
        push_text("ab", 1'b0);
        push_text("ij", 1'b0);
        push_text("zz", 1'b1);
        push_text("q", 1'b1);
        settle();

        // Keyword square for "moonmission", j left out.
        load_text_square("monisabcdefghklpqrtuvwxyz");
        push_text("mo", 1'b0);           // same row
        push_text("ma", 1'b0);           // same column
        push_text("bz", 1'b0);           // rectangle
        push_text("eej", 1'b0);          // repeat split with pad, then j as i
        push_text("gh", 1'b1);           // pair closing the message
        push_text("xx", 1'b1);           // repeat on last letter: two pairs
        push_text("z", 1'b1);            // lone last letter padded
        settle();

        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase)
                1: program_square({CFG_DATA_W{1'b1}}, {CFG_DATA_W{1'b1}},
                                  letter_t'(25), 1'b0);
                3, 7:
                begin
                    // raw contents: duplicates and codes above z
                    ra = CFG_DATA_W'({$urandom, $urandom});
                    rb = CFG_DATA_W'({$urandom, $urandom});
                    program_square(ra, rb, letter_t'($urandom_range(25)), phase == 7);
                end
                5: program_square('0, '0, letter_t'(0), 1'b0);
                default: load_shuffled_square(phase == 6);
            endcase
            gapless   <= (phase == 2);
            want_hold <= (phase == 4);
            push_random_letters(PHASE_ITEMS);
            settle();
        end

        if (miss_count == 0)
            $display("playfair_digraph_encrypt_unit: match");
        else
            $display("playfair_digraph_encrypt_unit: mismatch");
        $finish;
    end

endmodule

### sim.f
design/pfe_pkg.sv
design/playfair_digraph_encrypt_unit.sv
dv/tb_playfair_digraph_encrypt_unit.sv
